// ===== sv/mvau_pkg.sv =====
// ----------------------------------------------------------------------------
// Masked vector ALU package
// Operation codes and the payload types of the instruction and result channels.
// ----------------------------------------------------------------------------
package mvau_pkg;

	localparam logic [3:0] OP_VADD      = 4'd0;
	localparam logic [3:0] OP_VSUB      = 4'd1;
	localparam logic [3:0] OP_ADDSCALAR = 4'd2;
	localparam logic [3:0] OP_SUBSCALAR = 4'd3;
	localparam logic [3:0] OP_MULSCALAR = 4'd4;
	localparam logic [3:0] OP_DIVSCALAR = 4'd5;
	localparam logic [3:0] OP_SHUFFLE   = 4'd6;
	localparam logic [3:0] OP_ACTIVATE  = 4'd7;
	localparam logic [3:0] OP_MINMAX    = 4'd8;
	localparam logic [3:0] OP_SETLEN    = 4'd9;
	localparam logic [3:0] OP_SETMASK   = 4'd10;

	localparam logic [4:0] ACT_RELU = 5'd0;
	localparam logic [4:0] SEL_MAX  = 5'd0;
	localparam logic [4:0] SEL_MIN  = 5'd1;

	localparam int unsigned MASK_BITS = 32;
	localparam logic [MASK_BITS-1:0] MASK_RESET = 32'hffff_ffff;
	localparam logic [15:0] DIV_BY_ZERO = 16'hffff;

	typedef struct packed {
		logic [3:0]  operation;
		logic [4:0]  dest_reg;
		logic [4:0]  src_a_reg;
		logic [4:0]  src_b_reg;
		logic [63:0] scalar_a;
		logic [4:0]  mask_select;
	} in_t;

	typedef struct packed {
		logic signed [15:0] result_value;
		logic               illegal;
	} out_t;

endpackage

// ===== sv/mvau_vrf.sv =====
// ----------------------------------------------------------------------------
// Vector register file
// Lane memory with two synchronous read ports, one write port and a valid bit
// per register row; a row never written reads as zero.
// ----------------------------------------------------------------------------
module mvau_vrf #(
	parameter int NUM_VREGS = 32,
	parameter int LANES     = 32,
	localparam int RW = (NUM_VREGS > 1) ? $clog2(NUM_VREGS) : 1,
	localparam int AW = $clog2(NUM_VREGS * LANES)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [AW-1:0] rd_addr0,
	input  logic [RW-1:0] rd_row0,
	input  logic [AW-1:0] rd_addr1,
	input  logic [RW-1:0] rd_row1,
	output logic [15:0]   rd_data0,
	output logic [15:0]   rd_data1,
	input  logic          we,
	input  logic [AW-1:0] wr_addr,
	input  logic [RW-1:0] wr_row,
	input  logic [15:0]   wr_data
);

	logic [15:0] mem [NUM_VREGS*LANES];
	logic [NUM_VREGS-1:0] row_vld_q;
	logic [15:0] data0_q, data1_q;
	logic vld0_q, vld1_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		data0_q <= mem[rd_addr0];
		data1_q <= mem[rd_addr1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			vld0_q    <= 1'b0;
			vld1_q    <= 1'b0;
		end else begin
			if (we) begin
				row_vld_q[wr_row] <= 1'b1;
			end
			vld0_q <= row_vld_q[rd_row0];
			vld1_q <= row_vld_q[rd_row1];
		end
	end

	assign rd_data0 = vld0_q ? data0_q : 16'd0;
	assign rd_data1 = vld1_q ? data1_q : 16'd0;

endmodule

// ===== sv/mvau_div.sv =====
// ----------------------------------------------------------------------------
// Lane divider
// Restoring unsigned 16-bit by 16-bit divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mvau_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] dividend,
	input  logic [15:0] divisor,
	output logic        done,
	output logic [15:0] quotient
);

	logic [16:0] rem_q;
	logic [15:0] dvd_q, dvs_q;
	logic [4:0]  cnt_q;
	logic        done_q;
	logic [16:0] rem_shift;
	logic        fits;

	assign rem_shift = {rem_q[15:0], dvd_q[15]};
	assign fits      = rem_shift >= {1'b0, dvs_q};

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dvs_q <= divisor;
		end else if (cnt_q != 5'd0) begin
			rem_q <= fits ? (rem_shift - {1'b0, dvs_q}) : rem_shift;
			dvd_q <= {dvd_q[14:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= 5'd16;
			end else if (cnt_q != 5'd0) begin
				cnt_q <= cnt_q - 5'd1;
				done_q <= cnt_q == 5'd1;
			end
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

// ===== sv/masked_vector_alu_unit.sv =====
// ----------------------------------------------------------------------------
// Masked vector ALU unit
// Executes one vector instruction per transaction against a vector register
// memory, lane masks and an active length.
// ----------------------------------------------------------------------------
// Each transaction returns one result. Set length, set mask, illegal and
// undefined operations go straight to the final state and present their result
// from there. Lane operations walk the lanes one at a time through the
// synchronous-read register memory: each lane passes a read and an execute state,
// a shuffle lane adds the index read states, and a divide lane whose operand needs
// the divider waits in the divide state for its quotient. Operations that write a
// register then copy the staged lanes back in the writeback state. A new
// transaction is taken while the previous result still waits at the output.
module masked_vector_alu_unit #(
	parameter int NUM_VREGS = 32,
	parameter int LANES     = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  mvau_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output mvau_pkg::out_t out_data
);

	import mvau_pkg::*;

	localparam int RW   = (NUM_VREGS > 1) ? $clog2(NUM_VREGS) : 1;
	localparam int LW   = (LANES > 1) ? $clog2(LANES) : 1;
	localparam int LENW = $clog2(LANES + 1);
	localparam int AW   = $clog2(NUM_VREGS * LANES);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1;
	localparam logic [2:0] S_EX   = 3'd2;
	localparam logic [2:0] S_SH   = 3'd3;
	localparam logic [2:0] S_SH2  = 3'd4;
	localparam logic [2:0] S_DIV  = 3'd5;
	localparam logic [2:0] S_WB   = 3'd6;
	localparam logic [2:0] S_FIN  = 3'd7;

	function automatic logic [RW-1:0] reg_mod(input logic [4:0] v);
		logic [31:0] x;
		logic [31:0] d;
		x = 32'(v);
		for (int k = 4; k >= 0; k--) begin
			d = 32'(NUM_VREGS) << k;
			if (x >= d) x = x - d;
		end
		return RW'(x);
	endfunction

	function automatic logic [15:0] lane_mod_hi(input logic [15:0] v);
		logic [31:0] x;
		logic [31:0] d;
		x = 32'(v);
		for (int k = 15; k >= 8; k--) begin
			d = 32'(LANES) << k;
			if (x >= d) x = x - d;
		end
		return x[15:0];
	endfunction

	function automatic logic [LW-1:0] lane_mod_lo(input logic [15:0] v);
		logic [31:0] x;
		logic [31:0] d;
		x = 32'(v);
		for (int k = 7; k >= 0; k--) begin
			d = 32'(LANES) << k;
			if (x >= d) x = x - d;
		end
		return LW'(x);
	endfunction

	function automatic logic lane_on(input logic [MASK_BITS-1:0] m, input logic [6:0] l);
		if (l >= 7'(MASK_BITS)) return 1'b1;
		return m[l[4:0]];
	endfunction

	logic [2:0]  state_q;
	logic [3:0]  op_q;
	logic [RW-1:0] rd_q, ra_q, rb_q;
	logic        minsel_q;
	logic [63:0] xs_q;
	logic [MASK_BITS-1:0] mask_a_q, mask_b_q;
	logic [MASK_BITS-1:0] mask_mem [NUM_VREGS];
	logic [NUM_VREGS-1:0] mask_vld_q;
	logic [LENW-1:0] len_q;
	logic [LW-1:0]   lane_q;
	logic [LENW-1:0] wb_cnt_q;
	logic signed [15:0] best_q;
	logic        illegal_q;
	logic        out_valid_q;
	out_t        out_q;
	logic [15:0] resbuf [LANES];
	logic [15:0] sh_rem_q;
	logic [15:0] wb_data_s1;
	logic [LW-1:0] wb_lane_s1;
	logic        wb_vld_s1;

	logic        accept;
	logic [RW-1:0] in_ra, in_rb, in_rd, in_ms;
	logic [RW-1:0] rb_row;
	logic [15:0] a_d, b_d;
	logic [AW-1:0] rd_addr0, rd_addr1, wr_addr;
	logic [LW-1:0] sh_idx;
	logic [6:0]  lane7;
	logic        on_a, on_b, lt;
	logic [15:0] ma, mb, xs16, lane_val;
	logic [31:0] prod;
	logic        div_go, div_done;
	logic [15:0] div_q;
	logic        last;
	logic signed [15:0] best_n;
	logic        vrf_we;

	assign in_ready = state_q == S_IDLE;
	assign accept   = in_valid && in_ready;
	assign in_ra    = reg_mod(in_data.src_a_reg);
	assign in_rb    = reg_mod(in_data.src_b_reg);
	assign in_rd    = reg_mod(in_data.dest_reg);
	assign in_ms    = reg_mod(in_data.mask_select);

	assign rb_row   = (op_q == OP_ACTIVATE) ? rd_q : rb_q;
	assign sh_idx   = lane_mod_lo(sh_rem_q);
	assign rd_addr0 = AW'(ra_q) * AW'(LANES) + AW'((state_q == S_SH) ? sh_idx : lane_q);
	assign rd_addr1 = AW'(rb_row) * AW'(LANES) + AW'(lane_q);
	assign wr_addr  = AW'(rd_q) * AW'(LANES) + AW'(wb_lane_s1);
	assign vrf_we   = wb_vld_s1;

	mvau_vrf #(.NUM_VREGS(NUM_VREGS), .LANES(LANES)) u_vrf (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_addr0 (rd_addr0),
		.rd_row0  (ra_q),
		.rd_addr1 (rd_addr1),
		.rd_row1  (rb_row),
		.rd_data0 (a_d),
		.rd_data1 (b_d),
		.we       (vrf_we),
		.wr_addr  (wr_addr),
		.wr_row   (rd_q),
		.wr_data  (wb_data_s1)
	);

	assign lane7 = 7'(lane_q);
	assign on_a  = lane_on(mask_a_q, lane7);
	assign on_b  = lane_on(mask_b_q, lane7);
	assign lt    = lane7 < 7'(len_q);
	assign ma    = on_a ? a_d : 16'd0;
	assign mb    = on_b ? b_d : 16'd0;
	assign xs16  = xs_q[15:0];
	assign prod  = 32'(b_d) * 32'(xs16);
	assign last  = lane_q == LW'(LANES - 1);
	assign div_go = (op_q == OP_DIVSCALAR) && lt && on_b && (xs_q != 64'd0)
		&& (xs_q[63:16] == 48'd0);

	always_comb begin
		lane_val = 16'd0;
		unique case (op_q)
			OP_VADD:      lane_val = lt ? ma + mb : 16'd0;
			OP_VSUB:      lane_val = lt ? ma - mb : 16'd0;
			OP_ADDSCALAR: lane_val = (lt && on_b) ? b_d + xs16 : 16'd0;
			OP_SUBSCALAR: lane_val = (lt && on_b) ? b_d - xs16 : 16'd0;
			OP_MULSCALAR: lane_val = (lt && on_b) ? prod[15:0] : 16'd0;
			OP_DIVSCALAR: lane_val = (lt && on_b && xs_q == 64'd0) ? DIV_BY_ZERO : 16'd0;
			OP_ACTIVATE:  lane_val = lt ? (($signed(a_d) > 16'sd0) ? a_d : 16'd0) : b_d;
			default:      lane_val = 16'd0;
		endcase
	end

	always_comb begin
		best_n = (lane_q == '0) ? $signed(a_d) : best_q;
		if (lt && on_a) begin
			if (minsel_q ? ($signed(a_d) < best_n) : ($signed(a_d) > best_n)) begin
				best_n = $signed(a_d);
			end
		end
	end

	mvau_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_EX && div_go),
		.dividend (b_d),
		.divisor  (xs16),
		.done     (div_done),
		.quotient (div_q)
	);

	always_ff @(posedge clk) begin
		if (state_q == S_EX && !div_go && op_q != OP_SHUFFLE) begin
			resbuf[lane_q] <= lane_val;
		end else if (state_q == S_SH2) begin
			resbuf[lane_q] <= lt ? a_d : 16'd0;
		end else if (state_q == S_DIV && div_done) begin
			resbuf[lane_q] <= div_q;
		end
		if (state_q == S_EX) begin
			sh_rem_q <= lane_mod_hi(b_d);
		end
		wb_data_s1 <= resbuf[LW'(wb_cnt_q)];
		wb_lane_s1 <= LW'(wb_cnt_q);
		if (accept && in_data.operation == OP_SETMASK) begin
			mask_mem[in_ms] <= in_data.scalar_a[MASK_BITS-1:0];
		end
		if (accept) begin
			mask_a_q <= mask_vld_q[in_ra] ? mask_mem[in_ra] : MASK_RESET;
			mask_b_q <= mask_vld_q[in_rb] ? mask_mem[in_rb] : MASK_RESET;
			op_q     <= in_data.operation;
			rd_q     <= in_rd;
			ra_q     <= in_ra;
			rb_q     <= in_rb;
			minsel_q <= in_data.src_b_reg == SEL_MIN;
			xs_q     <= in_data.scalar_a;
		end
		if (state_q == S_FIN && (!out_valid_q || out_ready)) begin
			out_q.result_value <= best_q;
			out_q.illegal      <= illegal_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mask_vld_q  <= '0;
			len_q       <= LENW'(LANES);
			lane_q      <= '0;
			wb_cnt_q    <= '0;
			wb_vld_s1   <= 1'b0;
			best_q      <= '0;
			illegal_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			wb_vld_s1 <= 1'b0;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						lane_q    <= '0;
						wb_cnt_q  <= '0;
						best_q    <= '0;
						illegal_q <= 1'b0;
						state_q   <= S_FIN;
						priority case (1'b1)
							in_data.operation <= OP_SHUFFLE: state_q <= S_RD;
							in_data.operation == OP_ACTIVATE: begin
								if (in_data.src_b_reg != ACT_RELU) illegal_q <= 1'b1;
								else state_q <= S_RD;
							end
							in_data.operation == OP_MINMAX: begin
								if (in_data.src_b_reg != SEL_MAX && in_data.src_b_reg != SEL_MIN)
									illegal_q <= 1'b1;
								else state_q <= S_RD;
							end
							in_data.operation == OP_SETLEN: begin
								if (in_data.scalar_a > 64'(LANES)) illegal_q <= 1'b1;
								else len_q <= LENW'(in_data.scalar_a);
							end
							in_data.operation == OP_SETMASK: mask_vld_q[in_ms] <= 1'b1;
							default: ;
						endcase
					end
				end
				S_RD: state_q <= S_EX;
				S_EX: begin
					if (op_q == OP_MINMAX) best_q <= best_n;
					if (op_q == OP_SHUFFLE) state_q <= S_SH;
					else if (div_go) state_q <= S_DIV;
					else if (last) state_q <= (op_q == OP_MINMAX) ? S_FIN : S_WB;
					else begin
						lane_q  <= lane_q + LW'(1);
						state_q <= S_RD;
					end
				end
				S_SH: state_q <= S_SH2;
				S_SH2, S_DIV: begin
					if (state_q == S_SH2 || div_done) begin
						if (last) state_q <= S_WB;
						else begin
							lane_q  <= lane_q + LW'(1);
							state_q <= S_RD;
						end
					end
				end
				S_WB: begin
					if (wb_cnt_q != LENW'(LANES)) begin
						wb_vld_s1 <= 1'b1;
						wb_cnt_q  <= wb_cnt_q + LENW'(1);
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTH
	a_write_in_wb: assert property (@(posedge clk) disable iff (!arst_n)
		vrf_we |-> (state_q == S_WB || state_q == S_FIN))
		else $error("register memory written outside writeback");
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LENW'(LANES))
		else $error("vector length above lane count");
	a_illegal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && illegal_q) |-> best_q == 16'sd0)
		else $error("illegal transaction carries a nonzero result");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("ready held after a transaction was accepted");
`endif

endmodule

// ===== sim/tb_masked_vector_alu_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Masked vector ALU unit testbench
// Drives vector instructions into the unit with random idle bursts on both
// channels, predicts each result from a local copy of the register state and
// checks every returned transaction in order.
// ----------------------------------------------------------------------------
import mvau_pkg::*;

class alu_scoreboard;
	localparam int NREG = 32;
	localparam int NLANE = 32;
	logic [15:0] vregs [NREG][NLANE];
	logic [31:0] lmask [NREG];
	int unsigned vlen;
	out_t pending [$];
	int errors;

	function new();
		errors = 0;
		for (int r = 0; r < NREG; r++) begin
			lmask[r] = MASK_RESET;
			for (int i = 0; i < NLANE; i++) begin
				vregs[r][i] = '0;
			end
		end
		vlen = NLANE;
	endfunction

	function void note_instruction(in_t t);
		logic [15:0] a [NLANE];
		logic [15:0] b [NLANE];
		logic [15:0] res [NLANE];
		logic [15:0] ma, mb, x16;
		logic [31:0] msk_a, msk_b;
		logic signed [15:0] best, s;
		logic on;
		int unsigned len;
		out_t o;
		o = '0;
		len = (vlen > NLANE) ? NLANE : vlen;
		msk_a = lmask[t.src_a_reg];
		msk_b = lmask[t.src_b_reg];
		x16 = t.scalar_a[15:0];
		for (int i = 0; i < NLANE; i++) begin
			a[i] = vregs[t.src_a_reg][i];
			b[i] = vregs[t.src_b_reg][i];
			res[i] = '0;
		end
		case (t.operation)
			OP_VADD, OP_VSUB, OP_ADDSCALAR, OP_SUBSCALAR, OP_MULSCALAR, OP_DIVSCALAR,
			OP_SHUFFLE: begin
				for (int i = 0; i < len; i++) begin
					on = msk_b[i];
					ma = msk_a[i] ? a[i] : 16'd0;
					mb = on ? b[i] : 16'd0;
					case (t.operation)
						OP_VADD: res[i] = ma + mb;
						OP_VSUB: res[i] = ma - mb;
						OP_ADDSCALAR: res[i] = on ? mb + x16 : 16'd0;
						OP_SUBSCALAR: res[i] = on ? mb - x16 : 16'd0;
						OP_MULSCALAR: res[i] = on ? mb * x16 : 16'd0;
						OP_DIVSCALAR: begin
							if (!on) res[i] = 16'd0;
							else if (t.scalar_a == 64'd0) res[i] = DIV_BY_ZERO;
							else res[i] = 16'({48'd0, mb} / t.scalar_a);
						end
						default: res[i] = a[b[i][4:0]];
					endcase
				end
				for (int i = 0; i < NLANE; i++) begin
					vregs[t.dest_reg][i] = res[i];
				end
			end
			OP_ACTIVATE: begin
				if (t.src_b_reg != ACT_RELU) begin
					o.illegal = 1'b1;
				end else begin
					for (int i = 0; i < len; i++) begin
						vregs[t.dest_reg][i] = ($signed(a[i]) > 0) ? a[i] : 16'd0;
					end
				end
			end
			OP_MINMAX: begin
				if (t.src_b_reg > SEL_MIN) begin
					o.illegal = 1'b1;
				end else begin
					best = a[0];
					for (int i = 0; i < len; i++) begin
						if (msk_a[i]) begin
							s = a[i];
							if (t.src_b_reg == SEL_MAX ? (s > best) : (s < best)) best = s;
						end
					end
					o.result_value = best;
				end
			end
			OP_SETLEN: begin
				if (t.scalar_a > NLANE) o.illegal = 1'b1;
				else vlen = t.scalar_a[5:0];
			end
			OP_SETMASK: lmask[t.mask_select] = t.scalar_a[31:0];
			default: ;
		endcase
		pending.push_back(o);
	endfunction

	function void check_result(out_t got);
		out_t want;
		if (pending.size() == 0) begin
			report_error("result with no instruction outstanding");
			return;
		end
		want = pending.pop_front();
		if (got.result_value !== want.result_value)
			report_error($sformatf("result_value %0d, expected %0d", got.result_value,
				want.result_value));
		if (got.illegal !== want.illegal)
			report_error($sformatf("illegal %b, expected %b", got.illegal, want.illegal));
	endfunction

	function void report_error(string msg);
		errors++;
		$display("ERROR at %0t: %s", $realtime, msg);
	endfunction
endclass

module tb_masked_vector_alu_unit;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;

	alu_scoreboard board = new();
	bit quiet_phase = 1'b0;
	bit hold_output = 1'b0;

	masked_vector_alu_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always #1 clk = ~clk;

	initial begin
		#4000000;
		$display("tb_masked_vector_alu_unit failed");
		$finish;
	end

	task automatic send_instruction(in_t t);
		@(negedge clk);
		in_data <= t;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		board.note_instruction(t);
		@(negedge clk);
		in_valid <= 1'b0;
		if (!quiet_phase && $urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
	endtask

	task automatic wait_drained();
		while (board.pending.size() != 0) @(posedge clk);
	endtask

	function automatic in_t make_instr(logic [3:0] op, logic [4:0] rd, logic [4:0] ra,
		logic [4:0] rb, logic [63:0] x, logic [4:0] ms);
		in_t t;
		t.operation = op;
		t.dest_reg = rd;
		t.src_a_reg = ra;
		t.src_b_reg = rb;
		t.scalar_a = x;
		t.mask_select = ms;
		return t;
	endfunction

	function automatic logic [63:0] rand_scalar();
		case ($urandom_range(0, 5))
			0: return 64'd0;
			1: return 64'($urandom_range(1, 7));
			2: return {$urandom, $urandom};
			3: return 64'hffff_ffff_ffff_ffff;
			default: return 64'($urandom_range(0, 16'hffff));
		endcase
	endfunction

	function automatic in_t random_instr();
		in_t t;
		int pick;
		t = make_instr(4'($urandom_range(0, 10)), 5'($urandom), 5'($urandom), 5'($urandom),
			rand_scalar(), 5'($urandom));
		pick = $urandom_range(0, 99);
		if (pick < 4) t.operation = 4'($urandom_range(11, 15));
		if (t.operation == OP_ACTIVATE && $urandom_range(0, 3) != 0) t.src_b_reg = ACT_RELU;
		if (t.operation == OP_MINMAX && $urandom_range(0, 4) != 0)
			t.src_b_reg = 5'($urandom_range(0, 1));
		if (t.operation == OP_SETLEN) begin
			if ($urandom_range(0, 4) == 0) t.scalar_a = rand_scalar();
			else t.scalar_a = 64'($urandom_range(0, 32));
		end
		if (t.operation == OP_DIVSCALAR && $urandom_range(0, 2) != 0)
			t.scalar_a = 64'($urandom_range(0, 300));
		if (t.operation == OP_SETMASK && $urandom_range(0, 2) == 0)
			t.scalar_a[31:0] = MASK_RESET;
		return t;
	endfunction

	// Receiver: random stall bursts, and one long hold while the sender keeps going.
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_output) begin
				out_ready <= 1'b0;
				repeat (3000) @(negedge clk);
				hold_output = 1'b0;
			end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 17) - 1) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) board.check_result(out_data);
	end

	initial begin
		int n;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Seed registers with extreme lane values through scalar adds.
		send_instruction(make_instr(OP_ADDSCALAR, 5'd1, 5'd0, 5'd0, 64'hffff, 5'd0));
		send_instruction(make_instr(OP_ADDSCALAR, 5'd2, 5'd0, 5'd0, 64'h8000, 5'd0));
		send_instruction(make_instr(OP_ADDSCALAR, 5'd3, 5'd0, 5'd0, 64'h7fff, 5'd0));
		send_instruction(make_instr(OP_SETMASK, 5'd0, 5'd0, 5'd0, 64'h5555_aaaa_a5a5_0ff0,
			5'd31));
		send_instruction(make_instr(OP_VADD, 5'd4, 5'd1, 5'd3, 64'd0, 5'd0));
		send_instruction(make_instr(OP_VSUB, 5'd5, 5'd2, 5'd31, 64'd0, 5'd0));
		send_instruction(make_instr(OP_SUBSCALAR, 5'd6, 5'd0, 5'd1, 64'hffff_ffff_ffff_1234,
			5'd0));
		send_instruction(make_instr(OP_MULSCALAR, 5'd7, 5'd0, 5'd3, 64'h0003, 5'd0));
		send_instruction(make_instr(OP_DIVSCALAR, 5'd8, 5'd0, 5'd1, 64'd0, 5'd0));
		send_instruction(make_instr(OP_DIVSCALAR, 5'd9, 5'd0, 5'd1, 64'h1_0000_0003, 5'd0));
		send_instruction(make_instr(OP_DIVSCALAR, 5'd10, 5'd0, 5'd2, 64'd7, 5'd0));
		send_instruction(make_instr(OP_SHUFFLE, 5'd11, 5'd4, 5'd1, 64'd0, 5'd0));
		send_instruction(make_instr(OP_ACTIVATE, 5'd12, 5'd2, ACT_RELU, 64'd0, 5'd0));
		send_instruction(make_instr(OP_ACTIVATE, 5'd12, 5'd3, 5'd31, 64'd0, 5'd0));
		send_instruction(make_instr(OP_MINMAX, 5'd0, 5'd5, SEL_MAX, 64'd0, 5'd0));
		send_instruction(make_instr(OP_MINMAX, 5'd0, 5'd5, SEL_MIN, 64'd0, 5'd0));
		send_instruction(make_instr(OP_MINMAX, 5'd0, 5'd5, 5'd2, 64'd0, 5'd0));
		send_instruction(make_instr(OP_SETLEN, 5'd0, 5'd0, 5'd0, 64'd33, 5'd0));
		send_instruction(make_instr(OP_SETLEN, 5'd0, 5'd0, 5'd0, 64'hffff_ffff_ffff_ffff,
			5'd0));
		send_instruction(make_instr(OP_SETLEN, 5'd0, 5'd0, 5'd0, 64'd0, 5'd0));
		send_instruction(make_instr(OP_VADD, 5'd13, 5'd1, 5'd1, 64'd0, 5'd0));
		send_instruction(make_instr(OP_SETLEN, 5'd0, 5'd0, 5'd0, 64'd5, 5'd0));
		send_instruction(make_instr(OP_ACTIVATE, 5'd4, 5'd2, ACT_RELU, 64'd0, 5'd0));
		send_instruction(make_instr(4'd15, 5'd31, 5'd31, 5'd31, 64'hffff_ffff_ffff_ffff,
			5'd31));
		send_instruction(make_instr(OP_SETLEN, 5'd0, 5'd0, 5'd0, 64'd32, 5'd0));

		// The sender pauses until every result is back.
		wait_drained();

		// Long receiver hold while instructions keep coming.
		hold_output = 1'b1;
		for (n = 0; n < 40; n++) send_instruction(random_instr());
		wait_drained();

		for (n = 0; n < 600; n++) begin
			if (n == 480) quiet_phase = 1'b1;
			send_instruction(random_instr());
		end
		wait_drained();
		repeat (200) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("tb_masked_vector_alu_unit passed");
		else
			$display("tb_masked_vector_alu_unit failed");
		$finish;
	end
endmodule
